// ===== rtl/elc_pkg.sv =====
// Shared types and constants of the EMA latency cooldown controller.
// Holds the sequencer state type, register indexes, reset values and
// the multiplier operand bundle. Depends on nothing.
package elc_pkg;

   // Widths of the shared multiplier and of the configuration index.
   localparam int MUL_A_WIDTH   = 17;
   localparam int MUL_B_WIDTH   = 32;
   localparam int PRODUCT_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int CSR_IDX_WIDTH = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EMA_WEIGHT      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TARGET_LATENCY  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BASE_COOLDOWN   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRESSURE_GAIN   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_COOLDOWN    = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_COOLDOWN    = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RECOVERY_WINDOW = 3'd6;

   // Operation codes of an input item.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Register reset values.
   localparam logic [16:0] RST_EMA_WEIGHT      = 17'd6554;
   localparam logic [31:0] RST_TARGET_LATENCY  = 32'd256000;
   localparam logic [31:0] RST_BASE_COOLDOWN   = 32'd25600;
   localparam logic [15:0] RST_PRESSURE_GAIN   = 16'd256;
   localparam logic [31:0] RST_MIN_COOLDOWN    = 32'd0;
   localparam logic [31:0] RST_MAX_COOLDOWN    = 32'd2560000;
   localparam logic [15:0] RST_RECOVERY_WINDOW = 16'd5;

   // Fixed-point constants: one in Q1.16, the Q0.16 rounding bias and
   // half a microsecond in 1/256 us units.
   localparam logic [16:0] ONE_Q16   = 17'h10000;
   localparam logic [PRODUCT_WIDTH-1:0] ROUND_Q16 = PRODUCT_WIDTH'(32768);
   localparam logic [PRODUCT_WIDTH-1:0] ROUND_Q8  = PRODUCT_WIDTH'(128);
   localparam logic [32:0] HALF_UNIT = 33'd128;

   // One-hot sequencer states.
   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_MUL_NEW = 10'b0000000010,
      S_MUL_OLD = 10'b0000000100,
      S_AVG     = 10'b0000001000,
      S_CMP     = 10'b0000010000,
      S_PRESS   = 10'b0000100000,
      S_CAND    = 10'b0001000000,
      S_CLAMP   = 10'b0010000000,
      S_COMMIT  = 10'b0100000000,
      S_DONE    = 10'b1000000000
   } elc_state_type;

   // Operands presented to the shared multiplier.
   typedef struct packed {
      logic [MUL_A_WIDTH-1:0] op_a;
      logic [MUL_B_WIDTH-1:0] op_b;
   } elc_mul_ops_type;

endpackage

// ===== rtl/ema_latency_cooldown_controller.sv =====
// Top level of the EMA latency cooldown controller: configuration registers,
// sequencer, state and result registers. Depends on elc_pkg and elc_mul.
// A clear item goes straight to the result. A sample is averaged and compared with
// target: at or below it starts or checks the recovery timer, on a recovery it is
// clamped, and above target a pressure term is added first; the single shared
// multiplier serves up to three passes. The next item is taken in the cycle after
// the result is loaded. Synchronous reset restores register defaults and state.
module ema_latency_cooldown_controller #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [31:0]                         req_latency_sample,
   input  logic [31:0]                         req_now_seconds,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_cooldown,
   output logic [31:0]                         rsp_average_latency,
   output logic                                rsp_cooldown_raised,
   output logic [31:0]                         rsp_expansion_count,
   output logic [31:0]                         rsp_recovery_count,
   output logic                                rsp_timer_running,
   // Configuration port
   input  logic                                csr_write_enable,
   input  logic [elc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                         csr_write_data
);
   import elc_pkg::*;

   // Configuration registers.
   logic [16:0] ema_weight_ff;
   logic [31:0] target_latency_ff;
   logic [31:0] base_cooldown_ff;
   logic [15:0] pressure_gain_ff;
   logic [31:0] min_cooldown_ff;
   logic [31:0] max_cooldown_ff;
   logic [15:0] recovery_window_ff;

   // Sequencer and controller state.
   elc_state_type            state_ff, state_in;
   logic [31:0]              average_ff, average_in;
   logic [31:0]              cooldown_ff, cooldown_in;
   logic                     timer_active_ff, timer_active_in;
   logic [31:0]              below_since_ff, below_since_in;
   logic [COUNT_WIDTH-1:0]   expansions_ff, expansions_in;
   logic [COUNT_WIDTH-1:0]   recoveries_ff, recoveries_in;

   // Per-item working registers.
   logic [31:0]              sample_ff, sample_in;
   logic [31:0]              now_ff, now_in;
   logic [PRODUCT_WIDTH-1:0] acc_ff, acc_in;
   logic [31:0]              excess_ff, excess_in;
   logic [31:0]              cand_ff, cand_in;
   logic [31:0]              clamped_ff, clamped_in;
   logic                     recover_ff, recover_in;

   // Result registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_cooldown_ff, rsp_cooldown_in;
   logic [31:0]              rsp_average_ff, rsp_average_in;
   logic                     rsp_pressure_ff, rsp_pressure_in;
   logic [31:0]              rsp_expansions_ff, rsp_expansions_in;
   logic [31:0]              rsp_recoveries_ff, rsp_recoveries_in;
   logic                     rsp_timer_ff, rsp_timer_in;

   // Shared multiplier.
   elc_mul_ops_type          mul_ops;
   logic [PRODUCT_WIDTH-1:0] product;

   // Combinational helpers.
   logic [16:0]              weight_sat;
   logic [PRODUCT_WIDTH-1:0] avg_sum;
   logic [PRODUCT_WIDTH-1:0] press_rounded;
   logic [40:0]              cand_wide;
   logic [31:0]              elapsed;

   elc_mul u_mul (
      .clock    (clock),
      .operands (mul_ops),
      .product  (product)
   );

   // A weight above one acts as one.
   assign weight_sat    = (ema_weight_ff > ONE_Q16) ? ONE_Q16 : ema_weight_ff;
   assign avg_sum       = acc_ff + product;
   assign press_rounded = product + ROUND_Q8;
   assign cand_wide     = {9'd0, base_cooldown_ff} + press_rounded[48:8];
   assign elapsed       = now_ff - below_since_ff;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         ema_weight_ff      <= RST_EMA_WEIGHT;
         target_latency_ff  <= RST_TARGET_LATENCY;
         base_cooldown_ff   <= RST_BASE_COOLDOWN;
         pressure_gain_ff   <= RST_PRESSURE_GAIN;
         min_cooldown_ff    <= RST_MIN_COOLDOWN;
         max_cooldown_ff    <= RST_MAX_COOLDOWN;
         recovery_window_ff <= RST_RECOVERY_WINDOW;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EMA_WEIGHT:      ema_weight_ff      <= csr_write_data[16:0];
            CSR_TARGET_LATENCY:  target_latency_ff  <= csr_write_data;
            CSR_BASE_COOLDOWN:   base_cooldown_ff   <= csr_write_data;
            CSR_PRESSURE_GAIN:   pressure_gain_ff   <= csr_write_data[15:0];
            CSR_MIN_COOLDOWN:    min_cooldown_ff    <= csr_write_data;
            CSR_MAX_COOLDOWN:    max_cooldown_ff    <= csr_write_data;
            CSR_RECOVERY_WINDOW: recovery_window_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in          = state_ff;
      average_in        = average_ff;
      cooldown_in       = cooldown_ff;
      timer_active_in   = timer_active_ff;
      below_since_in    = below_since_ff;
      expansions_in     = expansions_ff;
      recoveries_in     = recoveries_ff;
      sample_in         = sample_ff;
      now_in            = now_ff;
      acc_in            = acc_ff;
      excess_in         = excess_ff;
      cand_in           = cand_ff;
      clamped_in        = clamped_ff;
      recover_in        = recover_ff;
      rsp_cooldown_in   = rsp_cooldown_ff;
      rsp_average_in    = rsp_average_ff;
      rsp_pressure_in   = rsp_pressure_ff;
      rsp_expansions_in = rsp_expansions_ff;
      rsp_recoveries_in = rsp_recoveries_ff;
      rsp_timer_in      = rsp_timer_ff;
      mul_ops.op_a      = '0;
      mul_ops.op_b      = '0;
      // A waiting result stays until the downstream side takes it.
      rsp_valid_in      = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_CLEAR) begin
                  // A clear item restores the controller state from the current target and base.
                  average_in      = target_latency_ff;
                  cooldown_in     = base_cooldown_ff;
                  timer_active_in = 1'b0;
                  below_since_in  = '0;
                  expansions_in   = '0;
                  recoveries_in   = '0;
                  state_in        = S_DONE;
               end else begin
                  sample_in = req_latency_sample;
                  now_in    = req_now_seconds;
                  state_in  = S_MUL_NEW;
               end
            end
         end
         S_MUL_NEW: begin
            // Weighted new sample.
            mul_ops.op_a = weight_sat;
            mul_ops.op_b = sample_ff;
            state_in     = S_MUL_OLD;
         end
         S_MUL_OLD: begin
            // Weighted old average, while the first product is banked.
            mul_ops.op_a = ONE_Q16 - weight_sat;
            mul_ops.op_b = average_ff;
            acc_in       = product + ROUND_Q16;
            state_in     = S_AVG;
         end
         S_AVG: begin
            average_in = avg_sum[47:16];
            state_in   = S_CMP;
         end
         S_CMP: begin
            excess_in = average_ff - target_latency_ff;
            priority if (average_ff > target_latency_ff) begin
               recover_in = 1'b0;
               state_in   = S_PRESS;
            end else if (!timer_active_ff) begin
               // First item at or below target starts the timer.
               below_since_in  = now_ff;
               timer_active_in = 1'b1;
               state_in        = S_DONE;
            end else if (elapsed >= {16'd0, recovery_window_ff}) begin
               cand_in    = base_cooldown_ff;
               recover_in = 1'b1;
               state_in   = S_CLAMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PRESS: begin
            mul_ops.op_a = {1'b0, pressure_gain_ff};
            mul_ops.op_b = excess_ff;
            state_in     = S_CAND;
         end
         S_CAND: begin
            // Base plus the rounded pressure term (Q8.8 gain times excess), saturated to 32 bits.
            cand_in  = (|cand_wide[40:32]) ? '1 : cand_wide[31:0];
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            // The lower bound is checked first, so it wins over the upper one.
            priority if (cand_ff < min_cooldown_ff) begin
               clamped_in = min_cooldown_ff;
            end else if (cand_ff > max_cooldown_ff) begin
               clamped_in = max_cooldown_ff;
            end else begin
               clamped_in = cand_ff;
            end
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // Count changes larger than half a microsecond.
            if (recover_ff) begin
               if ({1'b0, clamped_ff} + HALF_UNIT < {1'b0, cooldown_ff}) begin
                  recoveries_in = recoveries_ff + COUNT_WIDTH'(1);
               end
            end else begin
               if ({1'b0, clamped_ff} > {1'b0, cooldown_ff} + HALF_UNIT) begin
                  expansions_in = expansions_ff + COUNT_WIDTH'(1);
               end
            end
            cooldown_in     = clamped_ff;
            timer_active_in = 1'b0;
            state_in        = S_DONE;
         end
         S_DONE: begin
            // Load the result once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_cooldown_in   = cooldown_ff;
               rsp_average_in    = average_ff;
               rsp_pressure_in   = cooldown_ff > base_cooldown_ff;
               rsp_expansions_in = 32'(expansions_ff);
               rsp_recoveries_in = 32'(recoveries_ff);
               rsp_timer_in      = timer_active_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         average_ff      <= RST_TARGET_LATENCY;
         cooldown_ff     <= RST_BASE_COOLDOWN;
         timer_active_ff <= 1'b0;
         below_since_ff  <= '0;
         expansions_ff   <= '0;
         recoveries_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         average_ff      <= average_in;
         cooldown_ff     <= cooldown_in;
         timer_active_ff <= timer_active_in;
         below_since_ff  <= below_since_in;
         expansions_ff   <= expansions_in;
         recoveries_ff   <= recoveries_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      sample_ff         <= sample_in;
      now_ff            <= now_in;
      acc_ff            <= acc_in;
      excess_ff         <= excess_in;
      cand_ff           <= cand_in;
      clamped_ff        <= clamped_in;
      recover_ff        <= recover_in;
      rsp_cooldown_ff   <= rsp_cooldown_in;
      rsp_average_ff    <= rsp_average_in;
      rsp_pressure_ff   <= rsp_pressure_in;
      rsp_expansions_ff <= rsp_expansions_in;
      rsp_recoveries_ff <= rsp_recoveries_in;
      rsp_timer_ff      <= rsp_timer_in;
   end

   // Port drivers.
   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cooldown        = rsp_cooldown_ff;
   assign rsp_average_latency = rsp_average_ff;
   assign rsp_cooldown_raised = rsp_pressure_ff;
   assign rsp_expansion_count = rsp_expansions_ff;
   assign rsp_recovery_count  = rsp_recoveries_ff;
   assign rsp_timer_running   = rsp_timer_ff;

endmodule

// ===== rtl/elc_mul.sv =====
// Shared 17 x 32 bit unsigned multiplier with a registered product.
// Used by the controller sequencer for the average and the pressure term.
// Depends on elc_pkg.
module elc_mul (
   input  logic                                  clock,
   input  elc_pkg::elc_mul_ops_type              operands,
   output logic [elc_pkg::PRODUCT_WIDTH-1:0]     product
);
   import elc_pkg::*;

   logic [PRODUCT_WIDTH-1:0] product_ff;
   logic [PRODUCT_WIDTH-1:0] product_in;

   // One multiplication per cycle; the product is ready in the cycle after its operands.
   assign product_in = PRODUCT_WIDTH'(operands.op_a) * PRODUCT_WIDTH'(operands.op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== dv/tb_ema_latency_cooldown_controller.sv =====
// Self-checking testbench for ema_latency_cooldown_controller.
// Drives latency samples and clear items, tracks the expected cooldown
// state in a scoreboard class and compares every result. Needs elc_pkg.
`timescale 1ns / 1ps

module tb_ema_latency_cooldown_controller;
   import elc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 205;

   // One result transfer as seen on the rsp_ ports.
   typedef struct {
      logic [31:0] cooldown;
      logic [31:0] average_latency;
      logic        cooldown_raised;
      logic [31:0] expansion_count;
      logic [31:0] recovery_count;
      logic        timer_running;
   } backoff_result_type;

   // Tracks registers and controller state, and holds the results still due.
   class backoff_tracker_type;
      bit [16:0] weight;
      bit [31:0] target;
      bit [31:0] base;
      bit [15:0] gain;
      bit [31:0] floor_cd;
      bit [31:0] ceiling_cd;
      bit [15:0] window;

      bit [31:0] average;
      bit [31:0] cooldown;
      bit        timer_on;
      bit [31:0] below_since;
      bit [31:0] expansions;
      bit [31:0] recoveries;

      backoff_result_type due_results[$];
      int failures;

      function void restore_registers();
         weight     = RST_EMA_WEIGHT;
         target     = RST_TARGET_LATENCY;
         base       = RST_BASE_COOLDOWN;
         gain       = RST_PRESSURE_GAIN;
         floor_cd   = RST_MIN_COOLDOWN;
         ceiling_cd = RST_MAX_COOLDOWN;
         window     = RST_RECOVERY_WINDOW;
      endfunction

      function void clear_state();
         average     = target;
         cooldown    = base;
         timer_on    = 1'b0;
         below_since = '0;
         expansions  = '0;
         recoveries  = '0;
      endfunction

      // An index with no register behind it is dropped.
      function void set_register(logic [CSR_IDX_WIDTH-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_EMA_WEIGHT:      weight     = data[16:0];
            CSR_TARGET_LATENCY:  target     = data;
            CSR_BASE_COOLDOWN:   base       = data;
            CSR_PRESSURE_GAIN:   gain       = data[15:0];
            CSR_MIN_COOLDOWN:    floor_cd   = data;
            CSR_MAX_COOLDOWN:    ceiling_cd = data;
            CSR_RECOVERY_WINDOW: window     = data[15:0];
            default: ;
         endcase
      endfunction

      // The lower bound is tested first, so it wins when it lies above the upper one.
      function bit [31:0] clamp(bit [63:0] v);
         if (v < 64'(floor_cd)) return floor_cd;
         if (v > 64'(ceiling_cd)) return ceiling_cd;
         return v[31:0];
      endfunction

      // Advance the state by one accepted input transfer and queue its result.
      function void note_input(logic op, logic [31:0] sample, logic [31:0] now);
         bit [63:0] w;
         bit [63:0] acc;
         bit [63:0] add;
         bit [63:0] cand;
         bit [31:0] next_cd;
         bit [31:0] elapsed;
         backoff_result_type r;
         if (op == OP_CLEAR) begin
            clear_state();
         end else begin
            // Weights above one behave as exactly one.
            w = (weight > ONE_Q16) ? 64'(ONE_Q16) : 64'(weight);
            acc = w * 64'(sample) + (64'(ONE_Q16) - w) * 64'(average) + 64'd32768;
            average = acc[47:16];
            elapsed = now - below_since;
            if (average > target) begin
               add = (64'(gain) * 64'(average - target) + 64'd128) >> 8;
               cand = 64'(base) + add;
               if (cand > 64'hFFFF_FFFF) cand = 64'hFFFF_FFFF;
               next_cd = clamp(cand);
               if (64'(next_cd) > 64'(cooldown) + 64'd128) expansions++;
               cooldown = next_cd;
               timer_on = 1'b0;
            end else if (!timer_on) begin
               // Starting the timer never recovers in the same transfer.
               below_since = now;
               timer_on = 1'b1;
            end else if (elapsed >= 32'(window)) begin
               next_cd = clamp(64'(base));
               if (64'(next_cd) + 64'd128 < 64'(cooldown)) recoveries++;
               cooldown = next_cd;
               timer_on = 1'b0;
            end
         end
         r.cooldown        = cooldown;
         r.average_latency = average;
         r.cooldown_raised = cooldown > base;
         r.expansion_count = expansions;
         r.recovery_count  = recoveries;
         r.timer_running   = timer_on;
         due_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         failures++;
      endtask

      // Compare one result transfer with the oldest expectation.
      task check_result(backoff_result_type got);
         backoff_result_type want;
         if (due_results.size() == 0) begin
            report_mismatch("result transfer with no expectation waiting");
         end else begin
            want = due_results.pop_front();
            if (got.cooldown !== want.cooldown)
               report_mismatch($sformatf("cooldown %0d, expected %0d",
                                         got.cooldown, want.cooldown));
            if (got.average_latency !== want.average_latency)
               report_mismatch($sformatf("average_latency %0d, expected %0d",
                                         got.average_latency, want.average_latency));
            if (got.cooldown_raised !== want.cooldown_raised)
               report_mismatch($sformatf("cooldown_raised %b, expected %b",
                                         got.cooldown_raised, want.cooldown_raised));
            if (got.expansion_count !== want.expansion_count)
               report_mismatch($sformatf("expansion_count %0d, expected %0d",
                                         got.expansion_count, want.expansion_count));
            if (got.recovery_count !== want.recovery_count)
               report_mismatch($sformatf("recovery_count %0d, expected %0d",
                                         got.recovery_count, want.recovery_count));
            if (got.timer_running !== want.timer_running)
               report_mismatch($sformatf("timer_running %b, expected %b",
                                         got.timer_running, want.timer_running));
         end
      endtask

      task check_drained();
         if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_operation = OP_SAMPLE;
   logic [31:0]              req_latency_sample = '0;
   logic [31:0]              req_now_seconds = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [31:0]              rsp_cooldown;
   logic [31:0]              rsp_average_latency;
   logic                     rsp_cooldown_raised;
   logic [31:0]              rsp_expansion_count;
   logic [31:0]              rsp_recovery_count;
   logic                     rsp_timer_running;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [31:0]              csr_write_data = '0;

   backoff_tracker_type tracker = new();
   bit                  gaps_on = 1'b1;
   bit [31:0]           now_s = '0;
   int                  quiet_cycles = 0;

   ema_latency_cooldown_controller uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_latency_sample  (req_latency_sample),
      .req_now_seconds     (req_now_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cooldown        (rsp_cooldown),
      .rsp_average_latency (rsp_average_latency),
      .rsp_cooldown_raised (rsp_cooldown_raised),
      .rsp_expansion_count (rsp_expansion_count),
      .rsp_recovery_count  (rsp_recovery_count),
      .rsp_timer_running   (rsp_timer_running),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // Check each result transfer.
   always @(posedge clock) begin
      backoff_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.cooldown        = rsp_cooldown;
         got.average_latency = rsp_average_latency;
         got.cooldown_raised = rsp_cooldown_raised;
         got.expansion_count = rsp_expansion_count;
         got.recovery_count  = rsp_recovery_count;
         got.timer_running   = rsp_timer_running;
         tracker.check_result(got);
      end
   end

   // Receiver back-pressure in random bursts.
   initial begin
      forever begin
         @(posedge clock);
         if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: give up after a long stretch without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ema_latency_cooldown_controller test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, optionally after a random gap, and wait for its transfer.
   task send_item(logic op, logic [31:0] sample, logic [31:0] now);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_latency_sample <= sample;
      req_now_seconds    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_input(op, sample, now);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
   endtask

   task csr_write(logic [CSR_IDX_WIDTH-1:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   // Write every register, plus the unused index, once the block has gone idle.
   task program_all(logic [31:0] w, logic [31:0] tgt, logic [31:0] b, logic [31:0] g,
                    logic [31:0] lo, logic [31:0] hi, logic [31:0] win);
      logic [CSR_IDX_WIDTH-1:0] unused_idx;
      unused_idx = CSR_RECOVERY_WINDOW + CSR_IDX_WIDTH'(1);
      wait_drained();
      csr_write(CSR_EMA_WEIGHT, w);
      csr_write(CSR_TARGET_LATENCY, tgt);
      csr_write(CSR_BASE_COOLDOWN, b);
      csr_write(CSR_PRESSURE_GAIN, g);
      csr_write(CSR_MIN_COOLDOWN, lo);
      csr_write(CSR_MAX_COOLDOWN, hi);
      csr_write(CSR_RECOVERY_WINDOW, win);
      csr_write(unused_idx, $urandom);
      csr_write_enable <= 1'b0;
   endtask

   task program_random();
      logic [31:0] w;
      logic [31:0] tgt;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] g;
      logic [31:0] win;
      case ($urandom_range(0, 5))
         0:       w = 32'd0;
         1:       w = 32'(ONE_Q16);
         2:       w = $urandom_range(32'h10001, 32'h1FFFF);
         default: w = $urandom_range(2000, 65535);
      endcase
      tgt = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1000, 2000000);
      g   = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 1024);
      lo  = $urandom_range(0, 100000);
      hi  = lo + $urandom_range(0, 5000000);
      // Now and then the lower bound ends up above the upper one.
      if ($urandom_range(0, 4) == 0) begin
         hi = lo;
         lo = lo + $urandom_range(1, 50000);
      end
      case ($urandom_range(0, 9))
         0:       win = 32'hFFFF;
         1:       win = $urandom_range(0, 65535);
         default: win = $urandom_range(0, 6);
      endcase
      program_all(w, tgt, $urandom_range(0, 500000), g, lo, hi, win);
   endtask

   // Latency drawn relative to the current target: above, at or below it, or anywhere.
   function logic [31:0] pick_latency(int mode);
      logic [63:0] v;
      case (mode)
         0: begin
            v = 64'(tracker.target) + 64'($urandom_range(1, 1 << $urandom_range(4, 24)));
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
         end
         1: return $urandom_range(0, tracker.target);
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h0;
               1:       return 32'hFFFF_FFFF;
               2:       return tracker.target;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Seconds mostly creep forward, sometimes jump or sit just short of the wrap.
   task advance_clock();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) now_s = $urandom;
      else if (r < 5) now_s = 32'hFFFF_FFFF - $urandom_range(0, 8);
      else now_s = now_s + $urandom_range(0, 3);
   endtask

   task run_random_phase(bit last_phase);
      int sent;
      int kind;
      int len;
      int mode;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(1, 16);
         gaps_on = last_phase ? 1'b0 : ($urandom_range(0, 4) != 0);
         for (int i = 0; i < len; i++) begin
            advance_clock();
            if ($urandom_range(0, 39) == 0) begin
               send_item(OP_CLEAR, $urandom, $urandom);
            end else begin
               mode = (kind < 4) ? 0 : (kind < 8) ? 1 : $urandom_range(0, 2);
               send_item(OP_SAMPLE, pick_latency(mode), now_s);
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      tracker.restore_registers();
      tracker.clear_state();

      // Reset settings: timer start, no recovery inside the window, full-scale
      // sample, then a clear whose other fields are junk.
      send_item(OP_SAMPLE, 32'h0, 32'h0);
      send_item(OP_SAMPLE, 32'h0, 32'd3);
      send_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Weight above one and a zero window: the starting transfer still waits.
      program_all(32'h1FFFF, RST_TARGET_LATENCY, RST_BASE_COOLDOWN,
                  32'(RST_PRESSURE_GAIN), RST_MIN_COOLDOWN, RST_MAX_COOLDOWN, 32'd0);
      send_item(OP_SAMPLE, 32'h7FFF_FFFF, 32'd10);
      send_item(OP_SAMPLE, 32'h0, 32'hFFFF_FFFE);
      send_item(OP_SAMPLE, 32'h0, 32'hFFFF_FFFE);

      // Lower bound above upper bound, and elapsed time across the wrap.
      program_all(32'(ONE_Q16), 32'd1000, 32'd500, 32'hFFFF, 32'd5000, 32'd2000, 32'd4);
      send_item(OP_SAMPLE, 32'd1001, 32'd0);
      send_item(OP_SAMPLE, 32'd100000, 32'd1);
      send_item(OP_SAMPLE, 32'd0, 32'hFFFF_FFFE);
      send_item(OP_SAMPLE, 32'd0, 32'd2);

      // Candidate saturates at 32 bits, then a counted recovery.
      program_all(32'(ONE_Q16), 32'd0, 32'hFFFF_0000, 32'hFFFF, 32'd0, 32'hFFFF_FFFF,
                  32'd1);
      send_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'd5);
      send_item(OP_SAMPLE, 32'd0, 32'd6);
      send_item(OP_SAMPLE, 32'd0, 32'd7);

      // All-zero settings.
      program_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'd8);
      send_item(OP_CLEAR, 32'h0, 32'h0);
      send_item(OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA);

      // Fixed settings first, then random; the last phase never idles on either side.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            program_all(32'd32768, RST_TARGET_LATENCY, RST_BASE_COOLDOWN,
                        32'(RST_PRESSURE_GAIN), RST_MIN_COOLDOWN, RST_MAX_COOLDOWN,
                        32'd3);
         else
            program_random();
         run_random_phase(p == PHASES - 1);
      end

      wait_drained();
      repeat (12) @(posedge clock);
      tracker.check_drained();
      if (tracker.failures == 0)
         $display("ema_latency_cooldown_controller test passed");
      else
         $display("ema_latency_cooldown_controller test failed");
      $finish;
   end

endmodule

// ===== ema_latency_cooldown_controller.f =====
rtl/elc_pkg.sv
rtl/elc_mul.sv
rtl/ema_latency_cooldown_controller.sv
dv/tb_ema_latency_cooldown_controller.sv
